// ----- sv/pps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the preemptive priority scheduler
// Job and result words, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int MAX_PROCS_DEF = 16;

	// Priority register value that loses against every real priority
	localparam logic [8:0] NO_PRIO = 9'h100;

	// Result kinds
	localparam logic KIND_GANTT = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef struct packed {
		logic [14:0] arrival_time;
		logic [7:0]  burst_time;
		logic [7:0]  priority_req;
		logic        is_last;
	} job_t;

	typedef struct packed {
		logic        kind;
		logic [4:0]  process_id;
		logic [15:0] event_time;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic load;    // store the accepted job
		logic init;    // start a selection pass for the current tick
		logic scan;    // examine one table entry
		logic skip;    // jump time to the next arrival
		logic switch;  // emit a Gantt entry for the preempted job
		logic exec;    // run the chosen job for one tick
		logic fin;     // emit closing entry and clear the run
	} pps_cmd_t;

	typedef struct packed {
		logic job_last;
		logic none_left;
		logic scan_last;
		logic has_best;
		logic need_switch;
		logic out_free;
	} pps_stat_t;

endpackage

// ----- sv/pps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler sequencer
// Loads jobs, then per simulated tick scans the table and runs one job or skips to the next arrival.
// ----------------------------------------------------------------------------
module pps_ctrl
	import pps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_valid,
	output logic      job_ready,
	input  pps_stat_t stat,
	output pps_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_INIT   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_SWITCH = 3'd4;
	localparam logic [2:0] ST_EXEC   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0] state_q, state_d;

	assign job_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					cmd.load = 1'b1;
					if (stat.job_last) state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (stat.none_left) begin
					state_d = ST_FIN;
				end else begin
					cmd.init = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!stat.has_best) begin
					cmd.skip = 1'b1;
					state_d  = ST_INIT;
				end else if (stat.need_switch) begin
					state_d = ST_SWITCH;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_SWITCH: begin
				if (stat.out_free) begin
					cmd.switch = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_INIT;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ----- sv/pps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dp: scheduler datapath
// Job tables, run state, best-candidate search and the result register.
// ----------------------------------------------------------------------------
module pps_dp
	import pps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
)(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      job,
	input  pps_cmd_t  cmd,
	output pps_stat_t stat,
	output logic      res_valid,
	input  logic      res_ready,
	output res_t      res
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = IDX_W + 1;

	logic [14:0] arr_mem [MAX_PROCS];
	logic [7:0]  bur_mem [MAX_PROCS];
	logic [7:0]  pri_mem [MAX_PROCS];
	logic [7:0]  rem_mem [MAX_PROCS];

	logic [CNT_W-1:0] count_q, left_q;
	logic [15:0]      tick_q, minarr_q;
	logic [IDX_W-1:0] run_q, best_q, scan_q, raddr;
	logic             has_run_q, best_ok_q;
	logic [8:0]       bp_q;
	logic             res_valid_q;
	res_t             res_q;

	logic [14:0] r_arr;
	logic [7:0]  r_bur, r_pri, r_rem;
	logic        arrived, better, live;
	logic [15:0] ct, tat, wt;

	// pick the table row for this step
	always_comb begin
		if (cmd.init)      raddr = run_q;
		else if (cmd.scan) raddr = scan_q;
		else               raddr = best_q;
	end

	assign r_arr   = arr_mem[raddr];
	assign r_bur   = bur_mem[raddr];
	assign r_pri   = pri_mem[raddr];
	assign r_rem   = rem_mem[raddr];
	assign live    = (r_rem != 8'd0);
	assign arrived = ({1'b0, r_arr} <= tick_q);
	assign better  = ({1'b0, r_pri} < bp_q);

	// completion figures of the chosen job
	assign ct  = tick_q + 16'd1;
	assign tat = ct - {1'b0, r_arr};
	assign wt  = tat - {8'd0, r_bur};

	// job tables
	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CNT_W'(MAX_PROCS)) begin
			arr_mem[count_q[IDX_W-1:0]] <= job.arrival_time;
			bur_mem[count_q[IDX_W-1:0]] <= job.burst_time;
			pri_mem[count_q[IDX_W-1:0]] <= job.priority_req;
			rem_mem[count_q[IDX_W-1:0]] <= job.burst_time;
		end
		if (cmd.exec) rem_mem[best_q] <= r_rem - 8'd1;
	end

	// run state and candidate search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			left_q    <= '0;
			tick_q    <= '0;
			run_q     <= '0;
			has_run_q <= 1'b0;
			best_ok_q <= 1'b0;
			best_q    <= '0;
			bp_q      <= NO_PRIO;
			minarr_q  <= '1;
			scan_q    <= '0;
		end else begin
			if (cmd.load && count_q < CNT_W'(MAX_PROCS)) begin
				count_q <= count_q + CNT_W'(1);
				if (job.burst_time != 8'd0) left_q <= left_q + CNT_W'(1);
			end
			if (cmd.init) begin
				best_ok_q <= has_run_q && live;
				best_q    <= run_q;
				bp_q      <= (has_run_q && live) ? {1'b0, r_pri} : NO_PRIO;
				minarr_q  <= '1;
				scan_q    <= '0;
			end
			if (cmd.scan) begin
				if (arrived && better && live) begin
					best_ok_q <= 1'b1;
					best_q    <= scan_q;
					bp_q      <= {1'b0, r_pri};
				end
				if (live && !arrived && {1'b0, r_arr} < minarr_q) minarr_q <= {1'b0, r_arr};
				scan_q <= scan_q + IDX_W'(1);
			end
			if (cmd.skip) tick_q <= minarr_q;
			if (cmd.exec) begin
				run_q     <= best_q;
				has_run_q <= 1'b1;
				tick_q    <= ct;
				if (r_rem == 8'd1) left_q <= left_q - CNT_W'(1);
			end
			if (cmd.fin) begin
				count_q   <= '0;
				left_q    <= '0;
				tick_q    <= '0;
				run_q     <= '0;
				has_run_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.switch || (cmd.fin && has_run_q)
				|| (cmd.exec && r_rem == 8'd1)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.switch || cmd.fin) begin
			res_q.kind        <= KIND_GANTT;
			res_q.process_id  <= 5'(run_q) + 5'd1;
			res_q.event_time  <= tick_q;
			res_q.turnaround  <= '0;
			res_q.waiting     <= '0;
			res_q.last_result <= cmd.fin;
		end else if (cmd.exec && r_rem == 8'd1) begin
			res_q.kind        <= KIND_DONE;
			res_q.process_id  <= 5'(best_q) + 5'd1;
			res_q.event_time  <= ct;
			res_q.turnaround  <= tat;
			res_q.waiting     <= wt;
			res_q.last_result <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign stat.job_last    = job.is_last;
	assign stat.none_left   = (left_q == '0);
	assign stat.scan_last   = (({1'b0, scan_q} + CNT_W'(1)) == count_q);
	assign stat.has_best    = best_ok_q;
	assign stat.need_switch = has_run_q && (best_q != run_q);
	assign stat.out_free    = !res_valid_q || res_ready;

endmodule

// ----- sv/preemptive_priority_scheduler.sv -----
`timescale 1ns / 1ps
// Loading: a job word that is not last is taken and the job port stays open.
// A last word starts the run: each busy tick passes select, a scan of every stored job,
// decide and execute, with a switch step on a preemption; idle gaps jump to the next arrival.
// Throughput: one job word per cycle while loading; results wait in one output register.
// Reset: arst_n clears control state; job tables stay undefined until loaded.
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: top level
// Joins the sequencer and the datapath of the priority scheduler.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
	import pps_pkg::*;
#(
	parameter int MAX_PROCS = MAX_PROCS_DEF
)(
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	pps_cmd_t  cmd;
	pps_stat_t stat;

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pps_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ----- sv/pps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_checker: port-level checks of the scheduler
// Watches the job and result channels of the top level.
// ----------------------------------------------------------------------------
module pps_checker
	import pps_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input logic job_ready,
	input job_t job,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// keep loading open after a job that is not last
	a_load_open: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready && !job.is_last |=> job_ready)
		else $error("job port closed during loading");

	// close the job port once a run starts
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready && job.is_last |=> !job_ready)
		else $error("job port open right after last job");

	// results always name a real job
	a_pid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.process_id != 5'd0)
		else $error("result with job number zero");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.job_valid (job_valid),
	.job_ready (job_ready),
	.job       (job),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

// ----- sim/preemptive_priority_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb: self-checking bench of the scheduler
// Loads batches of jobs and compares every Gantt entry and completion record
// against an in-bench schedule simulation, under varying handshake idling.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;
	import pps_pkg::*;

	localparam int N_SLOTS     = 16;
	localparam int RAND_ITEMS  = 232;
	localparam int CYCLE_LIMIT = 2000000;

	// phases of handshake idling
	localparam int PH_NONE   = 0;
	localparam int PH_SEND   = 1;
	localparam int PH_RECV   = 2;
	localparam int PH_BOTH   = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic job_valid = 1'b0;
	logic job_ready;
	job_t job = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	job_t pending_jobs[$];
	res_t expected_res[$];
	int   total_jobs = 0;
	int   jobs_taken = 0;
	int   errors = 0;
	int   cycles = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   phase;

	// scheduler shadow state
	logic [14:0] arr_tab[N_SLOTS];
	logic [7:0]  bur_tab[N_SLOTS];
	logic [7:0]  pri_tab[N_SLOTS];
	logic [7:0]  rem_tab[N_SLOTS];
	int          n_stored = 0;
	int          n_left = 0;

	preemptive_priority_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #4 clk = ~clk;

	assign phase = (total_jobs == 0) ? PH_NONE : (jobs_taken * 4 / total_jobs) % 4;

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	function automatic res_t make_res(logic kind, int pid, int unsigned t, int unsigned tat,
			int unsigned wt);
		res_t r;
		r.kind        = kind;
		r.process_id  = pid[4:0];
		r.event_time  = t[15:0];
		r.turnaround  = tat[15:0];
		r.waiting     = wt[15:0];
		r.last_result = 1'b0;
		return r;
	endfunction

	// Store one job; on the last word run the whole schedule and queue its results
	task automatic schedule_job(job_t j);
		res_t        batch[$];
		int          best;
		int unsigned best_pri;
		int unsigned tick;
		int unsigned tat;
		int          running;
		bit          started;
		if (n_stored < N_SLOTS) begin
			arr_tab[n_stored] = j.arrival_time;
			bur_tab[n_stored] = j.burst_time;
			pri_tab[n_stored] = j.priority_req;
			rem_tab[n_stored] = j.burst_time;
			if (j.burst_time != 0) n_left++;
			n_stored++;
		end
		if (!j.is_last) return;
		tick = 0;
		running = 0;
		started = 1'b0;
		while (n_left > 0) begin
			best = -1;
			best_pri = 99999;
			if (started && rem_tab[running] != 0) begin
				best = running;
				best_pri = pri_tab[running];
			end
			for (int i = 0; i < n_stored; i++) begin
				if (arr_tab[i] <= tick && pri_tab[i] < best_pri && rem_tab[i] != 0) begin
					best = i;
					best_pri = pri_tab[i];
				end
			end
			if (best < 0) begin
				tick++;
				continue;
			end
			if (started && best != running)
				batch.push_back(make_res(KIND_GANTT, running + 1, tick, 0, 0));
			rem_tab[best]--;
			running = best;
			started = 1'b1;
			if (rem_tab[best] == 0) begin
				tat = tick + 1 - arr_tab[best];
				n_left--;
				batch.push_back(make_res(KIND_DONE, best + 1, tick + 1, tat,
					tat - bur_tab[best]));
			end
			tick++;
		end
		if (started) batch.push_back(make_res(KIND_GANTT, running + 1, tick, 0, 0));
		if (batch.size() > 0) batch[batch.size() - 1].last_result = 1'b1;
		foreach (batch[k]) expected_res.push_back(batch[k]);
		n_stored = 0;
		n_left = 0;
	endtask

	function automatic job_t mk_job(int at, int bt, int pr, bit last);
		job_t j;
		j.arrival_time = at[14:0];
		j.burst_time   = bt[7:0];
		j.priority_req = pr[7:0];
		j.is_last      = last;
		return j;
	endfunction

	// Driver: offer pending words, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (job_valid && job_ready) begin
				schedule_job(job);
				jobs_taken <= jobs_taken + 1;
			end
			if (!job_valid || job_ready) begin
				if (pending_jobs.size() > 0 &&
						!((phase == PH_SEND && $urandom_range(0, 99) < 56) ||
						  (phase == PH_BOTH && $urandom_range(0, 99) < 12))) begin
					job <= pending_jobs.pop_front();
					job_valid <= 1'b1;
				end else begin
					job_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once, early, so the input side backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && res_valid && jobs_taken > 30) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	// Monitor: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_res.size() == 0) begin
					report("unexpected word, process_id", res.process_id, 16'd0);
				end else begin
					res_t w;
					w = expected_res.pop_front();
					if (res.kind != w.kind) report("kind", res.kind, w.kind);
					if (res.process_id != w.process_id)
						report("process_id", res.process_id, w.process_id);
					if (res.event_time != w.event_time)
						report("event_time", res.event_time, w.event_time);
					if (res.turnaround != w.turnaround)
						report("turnaround", res.turnaround, w.turnaround);
					if (res.waiting != w.waiting) report("waiting", res.waiting, w.waiting);
					if (res.last_result != w.last_result)
						report("last_result", res.last_result, w.last_result);
				end
			end
			if (hold_left > 0 || (!hold_done && res_valid && jobs_taken > 30))
				res_ready <= 1'b0;
			else if (phase == PH_RECV)
				res_ready <= ($urandom_range(0, 99) >= 56);
			else if (phase == PH_BOTH)
				res_ready <= ($urandom_range(0, 99) >= 12);
			else
				res_ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("preemptive_priority_scheduler_tb: done, errors");
			$finish;
		end
	end

	initial begin
		int n;
		int at;
		int bt;
		int pr;
		bit wide_at;
		bit tie_pr;
		// single shortest job
		pending_jobs.push_back(mk_job(0, 1, 0, 1));
		// field extremes with a long idle gap
		pending_jobs.push_back(mk_job(0, 1, 0, 0));
		pending_jobs.push_back(mk_job(32767, 255, 255, 1));
		// preemption, priority tie, equal priority against the running job
		pending_jobs.push_back(mk_job(0, 5, 5, 0));
		pending_jobs.push_back(mk_job(2, 2, 1, 0));
		pending_jobs.push_back(mk_job(2, 2, 1, 0));
		pending_jobs.push_back(mk_job(3, 2, 5, 1));
		// zero burst among normal jobs
		pending_jobs.push_back(mk_job(1, 0, 0, 0));
		pending_jobs.push_back(mk_job(1, 3, 9, 1));
		// nothing to run
		pending_jobs.push_back(mk_job(0, 0, 3, 0));
		pending_jobs.push_back(mk_job(5, 0, 4, 1));
		// table overflow: last two words dropped, last still starts the run
		for (int i = 0; i < 18; i++)
			pending_jobs.push_back(mk_job(i, 1 + i % 3, 17 - i, i == 17));
		// random batches
		n = 0;
		while (n < RAND_ITEMS) begin
			int cnt;
			cnt = ($urandom_range(0, 99) < 5) ? $urandom_range(17, 19) : $urandom_range(1, 16);
			wide_at = ($urandom_range(0, 99) < 15);
			tie_pr = $urandom_range(0, 1);
			for (int i = 0; i < cnt; i++) begin
				at = wide_at ? $urandom_range(0, 32767) : $urandom_range(0, 40);
				if ($urandom_range(0, 99) < 3)      bt = 0;
				else if ($urandom_range(0, 99) < 3) bt = $urandom_range(1, 255);
				else                                bt = $urandom_range(1, 6);
				pr = tie_pr ? $urandom_range(0, 3) : $urandom_range(0, 255);
				pending_jobs.push_back(mk_job(at, bt, pr, i == cnt - 1));
			end
			n += cnt;
		end
		total_jobs = pending_jobs.size();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// drain: every word taken, every expected result seen, block idle again
		wait (jobs_taken == total_jobs);
		wait (expected_res.size() == 0);
		wait (job_ready);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("preemptive_priority_scheduler_tb: done, clean");
		else
			$display("preemptive_priority_scheduler_tb: done, errors");
		$finish;
	end

endmodule
